// File: rtl/mscr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mscr_pkg
// Shared constants, codes and types of the mass-spring chain reverb.
// ----------------------------------------------------------------------------
package mscr_pkg;

   localparam int NODES         = 14;
   localparam int DRIVE_INDEX   = 3;
   localparam int PICKUP_OFFSET = 4;

   localparam int TOTAL = NODES + 2;
   localparam int IDX_W = $clog2(TOTAL);

   localparam int PICK_RAW   = (PICKUP_OFFSET <= TOTAL) ? (TOTAL - PICKUP_OFFSET) : 0;
   localparam bit PICK_LIVE  = (PICK_RAW >= 1) && (PICK_RAW <= NODES);
   localparam bit DRIVE_LIVE = (DRIVE_INDEX >= 1) && (DRIVE_INDEX <= NODES);

   localparam logic [IDX_W-1:0] PICK_IDX  = IDX_W'(PICK_RAW);
   localparam logic [IDX_W-1:0] DRIVE_IDX = IDX_W'(DRIVE_INDEX);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NODES);

   // Q16 constants: 0.99 and 0.1
   localparam logic signed [32:0] DAMP_Q16 = 33'sd64881;
   localparam logic signed [32:0] GAIN_Q16 = 33'sd6554;

   localparam logic [30:0] STIFFNESS_RESET = 31'd32768;
   localparam logic [30:0] REST_RESET      = 31'd65536;
   localparam logic [30:0] INV_MASS_RESET  = 31'd65536;

   // Register indexes
   localparam int CSR_W = 2;
   localparam logic [CSR_W-1:0] CSR_STIFFNESS = 2'd0;
   localparam logic [CSR_W-1:0] CSR_REST      = 2'd1;
   localparam logic [CSR_W-1:0] CSR_INV_MASS  = 2'd2;

   // Datapath operations
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
   localparam logic [OP_W-1:0] OP_START   = 5'd1;
   localparam logic [OP_W-1:0] OP_DRV     = 5'd2;
   localparam logic [OP_W-1:0] OP_DRVSAVE = 5'd3;
   localparam logic [OP_W-1:0] OP_DIFF    = 5'd4;
   localparam logic [OP_W-1:0] OP_SQX     = 5'd5;
   localparam logic [OP_W-1:0] OP_SQY     = 5'd6;
   localparam logic [OP_W-1:0] OP_SQSUM   = 5'd7;
   localparam logic [OP_W-1:0] OP_ROOT    = 5'd8;
   localparam logic [OP_W-1:0] OP_FORCE   = 5'd9;
   localparam logic [OP_W-1:0] OP_ZERO    = 5'd10;
   localparam logic [OP_W-1:0] OP_FX      = 5'd11;
   localparam logic [OP_W-1:0] OP_FY      = 5'd12;
   localparam logic [OP_W-1:0] OP_DIVLD   = 5'd13;
   localparam logic [OP_W-1:0] OP_DIV     = 5'd14;
   localparam logic [OP_W-1:0] OP_AX      = 5'd15;
   localparam logic [OP_W-1:0] OP_AY      = 5'd16;
   localparam logic [OP_W-1:0] OP_ACC     = 5'd17;
   localparam logic [OP_W-1:0] OP_VX      = 5'd18;
   localparam logic [OP_W-1:0] OP_VY      = 5'd19;
   localparam logic [OP_W-1:0] OP_WR      = 5'd20;
   localparam logic [OP_W-1:0] OP_ADV     = 5'd21;
   localparam logic [OP_W-1:0] OP_OUT     = 5'd22;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic root_last;
      logic div_last;
      logic len_zero;
      logic idx_zero;
      logic idx_last;
   } stat_type;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] vx;
      logic [31:0] vy;
   } node_type;

   // State of a particle that has not been written since reset
   function automatic node_type node_reset(input logic [IDX_W-1:0] i);
      node_type n;
      n.px = 32'(i) * 32'(REST_RESET);
      n.py = 32'd0;
      n.vx = 32'd0;
      n.vy = 32'd0;
      return n;
   endfunction

endpackage
`default_nettype wire

// File: rtl/mscr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mscr_ctrl
// Sequencer: walks the springs one by one and issues datapath operations.
// ----------------------------------------------------------------------------
module mscr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire mscr_pkg::stat_type  stat,
   output mscr_pkg::cmd_type        cmd
);
   import mscr_pkg::*;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_DRV     = 5'd1;
   localparam logic [4:0] ST_DRVSAVE = 5'd2;
   localparam logic [4:0] ST_DIFF    = 5'd3;
   localparam logic [4:0] ST_SQX     = 5'd4;
   localparam logic [4:0] ST_SQY     = 5'd5;
   localparam logic [4:0] ST_SQSUM   = 5'd6;
   localparam logic [4:0] ST_ROOT    = 5'd7;
   localparam logic [4:0] ST_FORCE   = 5'd8;
   localparam logic [4:0] ST_FX      = 5'd9;
   localparam logic [4:0] ST_FY      = 5'd10;
   localparam logic [4:0] ST_DIVLD   = 5'd11;
   localparam logic [4:0] ST_DIV     = 5'd12;
   localparam logic [4:0] ST_AX      = 5'd13;
   localparam logic [4:0] ST_AY      = 5'd14;
   localparam logic [4:0] ST_ACC     = 5'd15;
   localparam logic [4:0] ST_VX      = 5'd16;
   localparam logic [4:0] ST_VY      = 5'd17;
   localparam logic [4:0] ST_WR      = 5'd18;
   localparam logic [4:0] ST_ADV     = 5'd19;
   localparam logic [4:0] ST_WAIT    = 5'd20;
   localparam logic [4:0] ST_DONE    = 5'd21;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_START;
               state_in = ST_DRV;
            end
         end
         ST_DRV: begin
            cmd.op   = OP_DRV;
            state_in = ST_DRVSAVE;
         end
         ST_DRVSAVE: begin
            cmd.op   = OP_DRVSAVE;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            cmd.op   = OP_SQX;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = OP_SQY;
            state_in = ST_SQSUM;
         end
         ST_SQSUM: begin
            cmd.op   = OP_SQSUM;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.op = OP_ROOT;
            if (stat.root_last) begin
               state_in = ST_FORCE;
            end
         end
         ST_FORCE: begin
            // a zero-length spring contributes nothing
            if (stat.len_zero) begin
               cmd.op   = OP_ZERO;
               state_in = ST_ACC;
            end else begin
               cmd.op   = OP_FORCE;
               state_in = ST_FX;
            end
         end
         ST_FX: begin
            cmd.op   = OP_FX;
            state_in = ST_FY;
         end
         ST_FY: begin
            cmd.op   = OP_FY;
            state_in = ST_DIVLD;
         end
         ST_DIVLD: begin
            cmd.op   = OP_DIVLD;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            if (stat.div_last) begin
               state_in = ST_AX;
            end
         end
         ST_AX: begin
            cmd.op   = OP_AX;
            state_in = ST_AY;
         end
         ST_AY: begin
            cmd.op   = OP_AY;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = stat.idx_zero ? ST_ADV : ST_VX;
         end
         ST_VX: begin
            cmd.op   = OP_VX;
            state_in = ST_VY;
         end
         ST_VY: begin
            cmd.op   = OP_VY;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.op   = OP_WR;
            state_in = stat.idx_last ? ST_DONE : ST_ADV;
         end
         ST_ADV: begin
            cmd.op   = OP_ADV;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_DIFF;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/mscr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mscr_dp
// Datapath: particle store, shared multiplier, root and divide units.
// ----------------------------------------------------------------------------
module mscr_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mscr_pkg::cmd_type             cmd,
   output mscr_pkg::stat_type                 stat,
   input  wire logic [31:0]                   sample,
   input  wire logic                          csr_we,
   input  wire logic [mscr_pkg::CSR_W-1:0]    csr_index,
   input  wire logic [30:0]                   csr_data,
   output logic [31:0]                        result
);
   import mscr_pkg::*;

   logic [30:0] stiff_ff, rest_ff, inv_ff;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] rd_addr;
   node_type         node_mem_ff [TOTAL];
   logic [TOTAL-1:0] node_valid_ff;
   node_type         rd_ff, cur_ff, nxt_ff, wr_word;

   logic [31:0] dx_ff, dy_ff, force_ff;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic signed [63:0] prod_ff;
   logic [31:0] prod_q;
   logic [63:0] prod_mag;

   logic [63:0] sq_n_ff, sq_r_ff, sq_bit_ff, sq_try;
   logic [31:0] len, stretch;

   logic [63:0] dq_x_ff, dq_y_ff;
   logic [31:0] drem_x_ff, drem_y_ff;
   logic        dneg_x_ff, dneg_y_ff;
   logic [5:0]  div_cnt_ff;
   logic [32:0] rx_t, ry_t, rx_sub, ry_sub;
   logic [31:0] qx, qy;

   logic [31:0] ax_ff, acc_cx_ff, acc_cy_ff, acc_nx_ff, acc_ny_ff, drv_ff;
   logic [31:0] vx_new_ff, vy_new, pick_ff, out_ff, drv_add;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFFNESS_RESET;
         rest_ff  <= REST_RESET;
         inv_ff   <= INV_MASS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STIFFNESS: stiff_ff <= csr_data;
            CSR_REST:      rest_ff  <= csr_data;
            CSR_INV_MASS:  inv_ff   <= csr_data;
            default:       ;
         endcase
      end
   end

   assign prod_q  = prod_ff[47:16];
   assign prod_mag = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
   assign len     = sq_r_ff[31:0];
   assign stretch = len - {1'b0, rest_ff};
   assign sq_try  = sq_r_ff + sq_bit_ff;
   assign qx      = dneg_x_ff ? (32'd0 - dq_x_ff[31:0]) : dq_x_ff[31:0];
   assign qy      = dneg_y_ff ? (32'd0 - dq_y_ff[31:0]) : dq_y_ff[31:0];
   assign rx_t    = {drem_x_ff, dq_x_ff[63]};
   assign ry_t    = {drem_y_ff, dq_y_ff[63]};
   assign rx_sub  = rx_t - {1'b0, len};
   assign ry_sub  = ry_t - {1'b0, len};
   assign vy_new  = prod_q + acc_cy_ff;
   assign drv_add = (DRIVE_LIVE && (rd_addr == DRIVE_IDX)) ? drv_ff : 32'd0;
   assign rd_addr = idx_ff + 1'b1;

   always_comb begin
      wr_word.px = cur_ff.px + vx_new_ff;
      wr_word.py = cur_ff.py + vy_new;
      wr_word.vx = vx_new_ff;
      wr_word.vy = vy_new;
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      case (cmd.op)
         OP_START: begin
            mul_a = {sample[31], sample};
            mul_b = GAIN_Q16;
         end
         OP_DRV: begin
            mul_a = {prod_q[31], prod_q};
            mul_b = {2'b00, inv_ff};
         end
         OP_SQX: begin
            mul_a = {dx_ff[31], dx_ff};
            mul_b = {dx_ff[31], dx_ff};
         end
         OP_SQY: begin
            mul_a = {dy_ff[31], dy_ff};
            mul_b = {dy_ff[31], dy_ff};
         end
         OP_FORCE: begin
            mul_a = {stretch[31], stretch};
            mul_b = {2'b00, stiff_ff};
         end
         OP_FX: begin
            mul_a = {dx_ff[31], dx_ff};
            mul_b = {prod_q[31], prod_q};
         end
         OP_FY: begin
            mul_a = {dy_ff[31], dy_ff};
            mul_b = {force_ff[31], force_ff};
         end
         OP_AX: begin
            mul_a = {qx[31], qx};
            mul_b = {2'b00, inv_ff};
         end
         OP_AY: begin
            mul_a = {qy[31], qy};
            mul_b = {2'b00, inv_ff};
         end
         OP_VX: begin
            mul_a = {cur_ff.vx[31], cur_ff.vx};
            mul_b = DAMP_Q16;
         end
         OP_VY: begin
            mul_a = {cur_ff.vy[31], cur_ff.vy};
            mul_b = DAMP_Q16;
         end
         default: ;
      endcase
   end

   assign mul_full = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= mul_full[63:0];
   end

   // Particle store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WR) begin
         node_mem_ff[idx_ff] <= wr_word;
      end
      rd_ff <= node_valid_ff[rd_addr] ? node_mem_ff[rd_addr] : node_reset(rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_valid_ff <= '0;
      end else if (cmd.op == OP_WR) begin
         node_valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            idx_ff    <= '0;
            cur_ff    <= node_reset('0);
            acc_cx_ff <= 32'd0;
            acc_cy_ff <= 32'd0;
         end
         OP_DRVSAVE: drv_ff <= prod_q;
         OP_DIFF: begin
            nxt_ff <= rd_ff;
            dx_ff  <= rd_ff.px - cur_ff.px;
            dy_ff  <= rd_ff.py - cur_ff.py;
         end
         OP_SQY: sq_n_ff <= prod_ff;
         OP_SQSUM: begin
            sq_n_ff   <= sq_n_ff + prod_ff;
            sq_r_ff   <= 64'd0;
            sq_bit_ff <= 64'd1 << 62;
         end
         OP_ROOT: begin
            if (sq_n_ff >= sq_try) begin
               sq_n_ff <= sq_n_ff - sq_try;
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         OP_ZERO: ax_ff <= 32'd0;
         OP_FX: force_ff <= prod_q;
         OP_FY: begin
            dq_x_ff   <= prod_mag;
            drem_x_ff <= 32'd0;
            dneg_x_ff <= prod_ff[63];
         end
         OP_DIVLD: begin
            dq_y_ff    <= prod_mag;
            drem_y_ff  <= 32'd0;
            dneg_y_ff  <= prod_ff[63];
            div_cnt_ff <= 6'd0;
         end
         OP_DIV: begin
            if (!rx_sub[32]) begin
               drem_x_ff <= rx_sub[31:0];
               dq_x_ff   <= {dq_x_ff[62:0], 1'b1};
            end else begin
               drem_x_ff <= rx_t[31:0];
               dq_x_ff   <= {dq_x_ff[62:0], 1'b0};
            end
            if (!ry_sub[32]) begin
               drem_y_ff <= ry_sub[31:0];
               dq_y_ff   <= {dq_y_ff[62:0], 1'b1};
            end else begin
               drem_y_ff <= ry_t[31:0];
               dq_y_ff   <= {dq_y_ff[62:0], 1'b0};
            end
            div_cnt_ff <= div_cnt_ff + 6'd1;
         end
         OP_AY: ax_ff <= prod_q;
         OP_ACC: begin
            // lower end gains, upper end loses
            acc_cx_ff <= acc_cx_ff + ax_ff;
            acc_cy_ff <= acc_cy_ff + prod_q;
            acc_nx_ff <= 32'd0 - ax_ff;
            acc_ny_ff <= drv_add - prod_q;
         end
         OP_VY: vx_new_ff <= prod_q + acc_cx_ff;
         OP_WR: begin
            if (PICK_LIVE && (idx_ff == PICK_IDX)) begin
               pick_ff <= wr_word.py;
            end
         end
         OP_ADV: begin
            cur_ff    <= nxt_ff;
            acc_cx_ff <= acc_nx_ff;
            acc_cy_ff <= acc_ny_ff;
            idx_ff    <= rd_addr;
         end
         OP_OUT: out_ff <= PICK_LIVE ? pick_ff : 32'd0;
         default: ;
      endcase
   end

   assign result = out_ff;

   always_comb begin
      stat.root_last = sq_bit_ff[0];
      stat.div_last  = &div_cnt_ff;
      stat.len_zero  = (sq_r_ff == 64'd0);
      stat.idx_zero  = (idx_ff == '0);
      stat.idx_last  = (idx_ff == LAST_IDX);
   end

endmodule
`default_nettype wire

// File: rtl/mass_spring_chain_reverb_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mass_spring_chain_reverb_unit
// Mass-spring chain reverb: one drive sample in, one pickup position out.
// ----------------------------------------------------------------------------
// Each accepted item is one Q15.16 drive sample; each result is the Q15.16
// vertical position of the pickup particle after one simulation step. The
// block works on one item at a time and walks the springs one by one, for
// the default chain of 14 free nodes (15 springs). Each spring runs a
// 32-step square root and, unless its length is zero, a 64-step pair of
// dividers in turn; every product is formed on a single shared 33x33
// multiplier. A new item is taken while the previous result still waits
// in the output register. Configuration writes are taken at any time and
// must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module mass_spring_chain_reverb_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [31:0]                  req_tdata,   // [31:0] sample_force
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [31:0]                       rsp_tdata,   // [31:0] output_sample
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [mscr_pkg::CSR_W-1:0]   csr_index,
   input  wire logic [30:0]                  csr_data
);
   import mscr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // configuration never stalls
   assign csr_ready = 1'b1;

   mscr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mscr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .sample    (req_tdata),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: bench/tb_mass_spring_chain_reverb_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mass_spring_chain_reverb_unit
// Self-checking bench for the mass-spring chain reverb.
// ----------------------------------------------------------------------------
// Drive samples go in on the req_ stream and pickup positions come back on
// the rsp_ stream. A local copy of the chain state, stepped once per
// accepted sample, predicts every pickup value. Each returned value is
// compared with the oldest prediction.
//
// The run has three phases:
// - directed samples at the field extremes under the reset settings;
// - register extremes, including writes to an unused register index;
// - random samples under a series of random settings.
// Both sides insert random gaps, with calm stretches that have none.
// ----------------------------------------------------------------------------
module tb_mass_spring_chain_reverb_unit;
   import mscr_pkg::*;

   localparam int  CYCLE_LIMIT = 4_000_000;
   localparam int  DRAIN_WAIT  = 2000;   // one full step with margin

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index;
   logic [30:0]       csr_data;

   mass_spring_chain_reverb_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------------
   // Chain model: a private copy of the particle state and the registers
   // ------------------------------------------------------------------------
   logic [31:0] pos_x [TOTAL];
   logic [31:0] pos_y [TOTAL];
   logic [31:0] vel_x [TOTAL];
   logic [31:0] vel_y [TOTAL];
   logic [30:0] stiffness_q;
   logic [30:0] rest_q;
   logic [30:0] inv_mass_q;

   logic [31:0] pickup_q [$];      // predicted pickup positions, oldest first
   int          mismatch_count;
   int          cycle_count;
   bit          calm;              // suppress gaps on both sides

   function automatic longint sx(input logic [31:0] v);
      return longint'($signed(v));
   endfunction

   // Q16 product: exact, floor shift by 16, keep 32 bits
   function automatic logic [31:0] qmul(input longint a, input longint b);
      longint p;
      p = a * b;
      return p[47:16];
   endfunction

   function automatic longint unsigned root64(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic reset_chain();
      for (int i = 0; i < TOTAL; i++) begin
         pos_x[i] = 32'(i) * 32'(REST_RESET);
         pos_y[i] = '0;
         vel_x[i] = '0;
         vel_y[i] = '0;
      end
      stiffness_q = STIFFNESS_RESET;
      rest_q      = REST_RESET;
      inv_mass_q  = INV_MASS_RESET;
   endtask

   // Advance the chain by one sample and return the pickup y position
   function automatic logic [31:0] step_chain(input logic [31:0] sample);
      logic [31:0]     acc_x [TOTAL];
      logic [31:0]     acc_y [TOTAL];
      logic [31:0]     gx, gy, drv, st32, ax, ay;
      longint          dx, dy, span, stretch, pull, q;
      longint unsigned sq;
      int              pick;
      for (int i = 0; i < TOTAL; i++) begin
         acc_x[i] = '0;
         acc_y[i] = '0;
      end
      if (DRIVE_LIVE) begin
         drv = qmul(sx(sample), longint'(GAIN_Q16));
         acc_y[DRIVE_INDEX] += qmul(sx(drv), longint'(inv_mass_q));
      end
      for (int i = 0; i + 1 < TOTAL; i++) begin
         gx   = pos_x[i+1] - pos_x[i];
         gy   = pos_y[i+1] - pos_y[i];
         dx   = sx(gx);
         dy   = sx(gy);
         sq   = longint'(dx * dx) + longint'(dy * dy);
         span = longint'(root64(sq));
         // coincident ends: the spring has no direction, so no force
         if (span == 0) continue;
         st32    = span[31:0] - {1'b0, rest_q};
         stretch = sx(st32);
         pull    = sx(qmul(stretch, longint'(stiffness_q)));
         q       = (dx * pull) / span;
         ax      = qmul(sx(q[31:0]), longint'(inv_mass_q));
         q       = (dy * pull) / span;
         ay      = qmul(sx(q[31:0]), longint'(inv_mass_q));
         acc_x[i]   += ax;
         acc_y[i]   += ay;
         acc_x[i+1] -= ax;
         acc_y[i+1] -= ay;
      end
      for (int i = 1; i <= NODES; i++) begin
         vel_x[i] = qmul(sx(vel_x[i]), longint'(DAMP_Q16)) + acc_x[i];
         vel_y[i] = qmul(sx(vel_y[i]), longint'(DAMP_Q16)) + acc_y[i];
         pos_x[i] += vel_x[i];
         pos_y[i] += vel_y[i];
      end
      pick = (PICK_RAW >= TOTAL) ? 0 : PICK_RAW;
      return pos_y[pick];
   endfunction

   // ------------------------------------------------------------------------
   // Clock, cycle limit and reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_mass_spring_chain_reverb_unit NOT OK");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch %s: got %h, expected %h at cycle %0d",
               what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stalls, and a compare on every accepted item
   // ------------------------------------------------------------------------
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = calm ? 0 : $urandom_range(14);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pickup_q.size() == 0) begin
            flag_mismatch("unexpected item", rsp_tdata, 32'hx);
         end else begin
            if (rsp_tdata !== pickup_q[0])
               flag_mismatch("output_sample", rsp_tdata, pickup_q[0]);
            pickup_q.pop_front();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender and register writes
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic [31:0] sample);
      int gap;
      gap = calm ? 0 : $urandom_range(14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      pickup_q.push_back(step_chain(sample));
   endtask

   // Hold until every prediction has been met, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pickup_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [30:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         CSR_STIFFNESS: stiffness_q = val;
         CSR_REST:      rest_q      = val;
         CSR_INV_MASS:  inv_mass_q  = val;
         default: ;     // unused index: drop
      endcase
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return 32'($signed($urandom_range(2 * 65536))) - 32'd65536;
         2:       return 32'($signed($urandom_range(2 * 4096))) - 32'd4096;
         default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      logic [31:0] edge_vals [8];
      edge_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA};
      calm = 1'b1;
      foreach (edge_vals[i]) send_sample(edge_vals[i]);
      calm = 1'b0;
      foreach (edge_vals[i]) send_sample(~edge_vals[i]);
      wait_idle();
   endtask

   // Register extremes; rest length changes leave positions where they are
   task automatic test_register_extremes();
      write_reg(CSR_STIFFNESS, 31'd0);
      write_reg(CSR_INV_MASS, 31'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      write_reg(CSR_STIFFNESS, 31'h7FFF_FFFF);
      write_reg(CSR_REST, 31'd0);
      send_sample(32'h0001_0000);
      write_reg(CSR_INV_MASS, 31'd0);
      write_reg(CSR_REST, 31'h7FFF_FFFF);
      send_sample(32'hFFFF_FFFF);
      // unused index: ignored by the block
      write_reg(2'd3, 31'h1234_5678);
      send_sample(32'h0000_0000);
      wait_idle();
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) begin
            write_reg(CSR_STIFFNESS, $urandom_range(3) == 0 ?
                      31'($urandom()) : 31'($urandom_range(65536)));
            write_reg(CSR_REST, $urandom_range(3) == 0 ?
                      31'($urandom()) : 31'($urandom_range(2 * 65536)));
            write_reg(CSR_INV_MASS, $urandom_range(3) == 0 ?
                      31'($urandom()) : 31'($urandom_range(2 * 65536)));
         end
         if (n % 40 == 0) calm = ($urandom_range(3) == 0);
         send_sample(rand_sample());
      end
      calm = 1'b0;
      wait_idle();
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      calm           = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      reset_chain();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_random(550);

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pickup_q.size() == 0) begin
         $display("tb_mass_spring_chain_reverb_unit OK");
      end else begin
         $display("tb_mass_spring_chain_reverb_unit NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
